[design/rbd_pkg.sv]
// Shared types and constants of the byte-aligned rANS decoder.
// Depends on nothing; every design file imports it.
`timescale 1ns / 1ps

package rbd_pkg;

  // field widths fixed by the item layout
  localparam int KIND_W      = 3;
  localparam int SLOT_IDX_W  = 12;
  localparam int SYM_CODE_W  = 8;
  localparam int FREQ_W      = 13;
  localparam int CUM_W       = 12;
  localparam int WINDOW_W    = 32;
  localparam int USED_W      = 3;
  localparam int STATUS_W    = 2;

  // coder state and renormalization
  localparam int STATE_W     = 31;
  localparam int BYTE_W      = 8;
  localparam int RENORM_MAX  = 3;
  localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(32'h0080_0000);
  localparam logic [USED_W-1:0]  START_BYTES = 3'd4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_SLOT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SYM  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DECODE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FINISH    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_START  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FINISH = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_START   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [SYM_CODE_W-1:0] symbol_code;
    logic [FREQ_W-1:0]     frequency;
    logic [CUM_W-1:0]      cum_start;
    logic [WINDOW_W-1:0]   window;
  } in_item_t;

  typedef struct packed {
    logic [SYM_CODE_W-1:0] decoded_symbol;
    logic [USED_W-1:0]     bytes_used;
    logic [STATUS_W-1:0]   status;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD_SLOT,
    OP_LOAD_SYM,
    OP_START,
    OP_DECODE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  start_ok;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [SYM_CODE_W-1:0] symbol_code;
    logic [FREQ_W-1:0]     frequency;
    logic [CUM_W-1:0]      cum_start;
    logic [WINDOW_W-1:0]   window;
  } cmd_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [CUM_W-1:0]  cum_start;
  } sym_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_SYM,
    ST_MUL,
    ST_DONE
  } back_state_t;

endpackage

[design/rbd_front.sv]
// Front end: accepts input words, classifies them into commands and queues them.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_front #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rbd_pkg::in_item_t in_item,
  output logic            full,
  output logic            cmd_valid,
  input  logic            cmd_take,
  output rbd_pkg::cmd_t   cmd
);
  import rbd_pkg::*;

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  cmd_t              new_cmd;
  logic              sym_in_range;
  logic              push_fire;
  logic              take_fire;

  assign sym_in_range = {1'b0, in_item.symbol_code} < (SYM_CODE_W + 1)'(SYMBOL_COUNT);

  // classify the word; an out-of-range symbol load turns into a no-op
  always_comb begin
    new_cmd.slot_index  = in_item.slot_index;
    new_cmd.symbol_code = in_item.symbol_code;
    new_cmd.frequency   = in_item.frequency;
    new_cmd.cum_start   = in_item.cum_start;
    new_cmd.window      = in_item.window;
    new_cmd.start_ok    = !in_item.window[WINDOW_W-1] &&
                          (in_item.window[STATE_W-1:STATE_W-BYTE_W] != '0);
    case (in_item.kind)
      KIND_LOAD_SLOT: new_cmd.op = OP_LOAD_SLOT;
      KIND_LOAD_SYM:  new_cmd.op = sym_in_range ? OP_LOAD_SYM : OP_NOP;
      KIND_START:     new_cmd.op = OP_START;
      KIND_DECODE:    new_cmd.op = OP_DECODE;
      KIND_FINISH:    new_cmd.op = OP_FINISH;
      default:        new_cmd.op = OP_NOP;
    endcase
  end

  assign full      = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign push_fire = push && !full;
  assign take_fire = cmd_take && cmd_valid;
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = take_fire ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push_fire) - (QPTR_W + 1)'(take_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

[design/rbd_back.sv]
// Back end: tables, coder state, decode sequencer and the result register.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_back #(
  parameter int SCALE_BITS   = 12,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  rbd_pkg::cmd_t      cmd,
  output logic               cmd_take,
  input  logic               pop,
  output logic               empty,
  output rbd_pkg::out_item_t out_item
);
  import rbd_pkg::*;

  localparam int SLOT_DEPTH = 1 << SCALE_BITS;
  localparam int SLOT_EXT_W = (SCALE_BITS > SLOT_IDX_W) ? SCALE_BITS : SLOT_IDX_W;
  localparam int SYM_IW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int QUOT_W     = STATE_W - SCALE_BITS;
  localparam int PROD_W     = FREQ_W + QUOT_W;

  back_state_t              state_r, state_nxt;
  cmd_t                     cur_r;
  logic [STATE_W-1:0]       coder_state_r, coder_state_nxt;
  logic                     stream_valid_r, stream_valid_nxt;
  logic [SYM_CODE_W-1:0]    slot_mem [SLOT_DEPTH];
  logic [SYM_CODE_W-1:0]    slot_q_r;
  sym_entry_t               sym_mem [SYMBOL_COUNT];
  sym_entry_t               sym_q_r;
  logic [PROD_W-1:0]        prod_r;
  logic [STATE_W-1:0]       x_r;
  out_item_t                out_r, res;
  logic                     out_valid_r;

  logic                     slot_rd_en, sym_rd_en, prod_en, x_en, done_fire;
  logic                     slot_wr_en, sym_wr_en;
  logic [SLOT_EXT_W-1:0]    slot_ext;
  logic [SCALE_BITS-1:0]    slot_wr_addr, slot_rd_addr;
  logic [QUOT_W-1:0]        quot;
  logic [STATE_W-1:0]       renorm_state;
  logic [USED_W-1:0]        renorm_used;

  assign slot_ext     = SLOT_EXT_W'(cur_r.slot_index);
  assign slot_wr_addr = slot_ext[SCALE_BITS-1:0];
  assign slot_rd_addr = coder_state_r[SCALE_BITS-1:0];
  assign quot         = coder_state_r[STATE_W-1:SCALE_BITS];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == OP_DECODE && stream_valid_r) ? ST_SLOT : ST_DONE;
        end
      end
      ST_SLOT: state_nxt = ST_SYM;
      ST_SYM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_take   = 1'b0;
    slot_rd_en = 1'b0;
    sym_rd_en  = 1'b0;
    prod_en    = 1'b0;
    x_en       = 1'b0;
    done_fire  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_take   = cmd_valid;
        slot_rd_en = cmd_valid && cmd.op == OP_DECODE && stream_valid_r;
      end
      ST_SLOT: sym_rd_en = 1'b1;
      ST_SYM:  prod_en   = 1'b1;
      ST_MUL:  x_en      = 1'b1;
      ST_DONE: done_fire = !out_valid_r || pop;
      default: ;
    endcase
  end

  // shift in up to three window bytes while the state is below the bound
  always_comb begin
    renorm_state = x_r;
    renorm_used  = '0;
    for (int i = 0; i < RENORM_MAX; i++) begin
      if (renorm_state < LOWER_BOUND) begin
        renorm_state = {renorm_state[STATE_W-BYTE_W-1:0], cur_r.window[BYTE_W*i +: BYTE_W]};
        renorm_used  = renorm_used + 1'b1;
      end
    end
  end

  // result and state update of the finished command
  always_comb begin
    res              = '0;
    coder_state_nxt  = coder_state_r;
    stream_valid_nxt = stream_valid_r;
    slot_wr_en       = 1'b0;
    sym_wr_en        = 1'b0;
    case (cur_r.op)
      OP_LOAD_SLOT: slot_wr_en = done_fire;
      OP_LOAD_SYM:  sym_wr_en  = done_fire;
      OP_START: begin
        if (cur_r.start_ok) begin
          coder_state_nxt  = cur_r.window[STATE_W-1:0];
          stream_valid_nxt = 1'b1;
          res.bytes_used   = START_BYTES;
        end else begin
          stream_valid_nxt = 1'b0;
          res.status       = STATUS_BAD_START;
        end
      end
      OP_DECODE: begin
        if (!stream_valid_r) begin
          res.status = STATUS_NO_START;
        end else begin
          coder_state_nxt    = renorm_state;
          res.decoded_symbol = slot_q_r;
          res.bytes_used     = renorm_used;
        end
      end
      OP_FINISH: begin
        stream_valid_nxt = 1'b0;
        res.status = (coder_state_r != LOWER_BOUND) ? STATUS_BAD_FINISH : STATUS_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      coder_state_r  <= '0;
      stream_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_fire) begin
        coder_state_r  <= coder_state_nxt;
        stream_valid_r <= stream_valid_nxt;
        out_valid_r    <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_r <= cmd;
    end
    if (prod_en) begin
      prod_r <= PROD_W'(sym_q_r.frequency) * PROD_W'(quot);
    end
    if (x_en) begin
      x_r <= STATE_W'(prod_r) + STATE_W'(slot_rd_addr) - STATE_W'(sym_q_r.cum_start);
    end
    if (done_fire) begin
      out_r <= res;
    end
  end

  // slot-to-symbol memory
  always_ff @(posedge clk) begin
    if (slot_wr_en) begin
      slot_mem[slot_wr_addr] <= cur_r.symbol_code;
    end
    if (slot_rd_en) begin
      slot_q_r <= slot_mem[slot_rd_addr];
    end
  end

  // frequency and cumulative start memory
  always_ff @(posedge clk) begin
    if (sym_wr_en) begin
      sym_mem[cur_r.symbol_code[SYM_IW-1:0]] <= '{frequency: cur_r.frequency,
                                                 cum_start: cur_r.cum_start};
    end
    if (sym_rd_en) begin
      sym_q_r <= sym_mem[slot_q_r[SYM_IW-1:0]];
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

endmodule

[design/rans_byte_decoder_top.sv]
// Byte-aligned rANS decoder, top level.
// Decode: each result passes through the chain slot memory read, symbol memory read,
// multiply, add and renormalize; the back end takes no new command until it is through.
// Other kinds go from accept to the result register through the back-end sequencer.
// Reset (rst_n, synchronous, active low) clears the queue, stream state and the
// result valid flag; tables hold no reset and must be loaded before use. Depends on rbd_pkg.
`timescale 1ns / 1ps

module rans_byte_decoder_top #(
  parameter int SCALE_BITS   = 12,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rbd_pkg::in_item_t  in_item,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output rbd_pkg::out_item_t out_item
);
  import rbd_pkg::*;

  // command word between the front and the back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  // front: accept input words, classify kind, range-check the start word,
  // and hold them in a short queue so input keeps flowing while a decode runs
  rbd_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd)
  );

  // back: run one command at a time against the tables and coder state,
  // and park its result word in the output register until popped
  rbd_back #(
    .SCALE_BITS  (SCALE_BITS),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  // back never takes a command from an empty queue
  a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

  // a full queue always offers a command to the back
  a_full_offers_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> cmd_valid)
    else $error("queue full but no command offered");

  // an error result carries no symbol and consumes no bytes
  a_error_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != STATUS_OK) |->
      (out_item.bytes_used == '0 && out_item.decoded_symbol == '0))
    else $error("error result with symbol or bytes");
`endif

endmodule

[bench/rans_byte_decoder_top_tb.sv]
// Testbench for the byte-aligned rANS decoder: directed corner words, then real encoded
// streams with lazily loaded tables mixed with random noise, checked by an in-bench predictor.
// Depends on rbd_pkg and rans_byte_decoder_top.
`timescale 1ns / 1ps

module rans_byte_decoder_top_tb;
  import rbd_pkg::*;

  localparam int SCALE_BITS    = 12;
  localparam int SYMBOL_COUNT  = 256;
  localparam int SLOT_DEPTH    = 1 << SCALE_BITS;
  localparam int WINDOW_BYTES  = WINDOW_W / BYTE_W;
  localparam int MAX_DIST_SYMS = 8;
  localparam int MAX_MSG_LEN   = 24;
  localparam int ITEM_TARGET   = 1550;
  localparam int QUIET_TAIL    = 120;    // no idling once this few words remain to send
  localparam int HOLD_AT       = 300;    // result count that triggers the long receiver hold
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 500000;

  // two copies of the decoder state: one steers generation, one predicts results
  localparam int MODEL_PLAN  = 0;
  localparam int MODEL_CHECK = 1;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_FINISH + 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  in_item_t  in_item;
  logic      full;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  rans_byte_decoder_top #(
    .SCALE_BITS  (SCALE_BITS),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder state, one copy per model
  // ---------------------------------------------------------------------------
  bit [STATE_W-1:0] coder [2];
  bit               live [2];
  bit [7:0]         slot_tab [2][SLOT_DEPTH];
  bit               slot_set [2][SLOT_DEPTH];
  bit [FREQ_W-1:0]  freq_tab [2][256];
  bit [CUM_W-1:0]   cum_tab [2][256];
  bit               sym_set [2][256];

  in_item_t  queued_words[$];      // words still to be offered, in order
  out_item_t predicted_words[$];   // results owed by the block, oldest first

  // current stream: symbol distribution and encoded bytes
  int       dist_n;
  bit [7:0] dist_code [MAX_DIST_SYMS];
  int       dist_freq [MAX_DIST_SYMS];
  int       dist_cum [MAX_DIST_SYMS];
  bit [7:0] stream_bytes[$];

  int fail_count = 0;
  int words_out  = 0;
  int cycles     = 0;
  int send_gap   = 0;
  int recv_gap   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  // Apply one word to model m and return the result word it owes.
  function automatic out_item_t rans_apply(input int m, input in_item_t it);
    out_item_t             r;
    bit [SCALE_BITS-1:0]   slot;
    bit [7:0]              sym;
    logic [63:0]           x;
    logic [STATE_W-1:0]    s;
    int                    nb;
    r = '0;
    case (it.kind)
      KIND_LOAD_SLOT: begin
        slot = it.slot_index[SCALE_BITS-1:0];
        slot_tab[m][slot] = it.symbol_code;
        slot_set[m][slot] = 1'b1;
      end
      KIND_LOAD_SYM: begin
        if (it.symbol_code < SYMBOL_COUNT) begin
          freq_tab[m][it.symbol_code] = it.frequency;
          cum_tab[m][it.symbol_code]  = it.cum_start;
          sym_set[m][it.symbol_code]  = 1'b1;
        end
      end
      KIND_START: begin
        // accept only [2^23, 2^31); a bad word keeps the old state
        if (it.window < WINDOW_W'(LOWER_BOUND) || it.window[WINDOW_W-1]) begin
          r.status = STATUS_BAD_START;
          live[m]  = 1'b0;
        end else begin
          coder[m]     = it.window[STATE_W-1:0];
          live[m]      = 1'b1;
          r.bytes_used = START_BYTES;
        end
      end
      KIND_DECODE: begin
        if (!live[m]) begin
          r.status = STATUS_NO_START;
        end else begin
          slot = coder[m][SCALE_BITS-1:0];
          sym  = slot_tab[m][slot];
          x = 64'(freq_tab[m][sym]) * 64'(coder[m] >> SCALE_BITS) + 64'(slot)
              - 64'(cum_tab[m][sym]);
          s  = x[STATE_W-1:0];
          nb = 0;
          // shift in at most three window bytes, low byte first
          while (s < LOWER_BOUND && nb < RENORM_MAX) begin
            s = {s[STATE_W-BYTE_W-1:0], it.window[BYTE_W*nb +: BYTE_W]};
            nb++;
          end
          coder[m]         = s;
          r.decoded_symbol = sym;
          r.bytes_used     = USED_W'(nb);
        end
      end
      KIND_FINISH: begin
        r.status = (coder[m] != LOWER_BOUND) ? STATUS_BAD_FINISH : STATUS_OK;
        live[m]  = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Queue a word for the sender and advance the planning model with it.
  function automatic out_item_t plan_push(input in_item_t it);
    queued_words.push_back(it);
    return rans_apply(MODEL_PLAN, it);
  endfunction

  // Fill every field with noise; callers override the ones that matter.
  function automatic in_item_t random_word(input logic [KIND_W-1:0] kind);
    in_item_t it;
    it.kind        = kind;
    it.slot_index  = SLOT_IDX_W'($urandom);
    it.symbol_code = SYM_CODE_W'($urandom);
    it.frequency   = FREQ_W'($urandom);
    it.cum_start   = CUM_W'($urandom);
    it.window      = $urandom;
    return it;
  endfunction

  function automatic in_item_t word_of(input logic [KIND_W-1:0] kind,
                                       input logic [SLOT_IDX_W-1:0] sidx,
                                       input logic [SYM_CODE_W-1:0] code,
                                       input logic [FREQ_W-1:0] freq,
                                       input logic [CUM_W-1:0] cum,
                                       input logic [WINDOW_W-1:0] win);
    in_item_t it;
    it = '{kind, sidx, code, freq, cum, win};
    return it;
  endfunction

  function automatic int dist_index(input int slot);
    for (int i = 0; i < dist_n; i++)
      if (slot < dist_cum[i] + dist_freq[i]) return i;
    return dist_n - 1;
  endfunction

  // Random alphabet of up to eight distinct codes whose frequencies sum to 2^SCALE_BITS.
  function automatic void make_distribution();
    int left;
    bit dup;
    dist_n = $urandom_range(MAX_DIST_SYMS, 1);
    left   = SLOT_DEPTH;
    for (int i = 0; i < dist_n; i++) begin
      do begin
        dist_code[i] = 8'($urandom);
        dup = 1'b0;
        for (int j = 0; j < i; j++)
          if (dist_code[j] == dist_code[i]) dup = 1'b1;
      end while (dup);
      dist_freq[i] = (i == dist_n - 1) ? left : $urandom_range(left - (dist_n - 1 - i), 1);
      dist_cum[i]  = SLOT_DEPTH - left;
      left -= dist_freq[i];
    end
  endfunction

  // Encode a random message in reverse, as a real rANS encoder would, so that decoding
  // it in order walks the state back to 2^23.
  function automatic void encode_message(input int len);
    int          msg[$];
    bit [7:0]    emitted[$];
    logic [63:0] x;
    logic [63:0] x_max;
    int          k;
    for (int i = 0; i < len; i++) msg.push_back($urandom_range(dist_n - 1, 0));
    stream_bytes.delete();
    x = 64'(LOWER_BOUND);
    for (int i = len - 1; i >= 0; i--) begin
      k = msg[i];
      x_max = ((64'(LOWER_BOUND) >> SCALE_BITS) << BYTE_W) * 64'(dist_freq[k]);
      while (x >= x_max) begin
        emitted.push_back(x[7:0]);
        x = x >> BYTE_W;
      end
      x = ((x / 64'(dist_freq[k])) << SCALE_BITS) + (x % 64'(dist_freq[k]))
          + 64'(dist_cum[k]);
    end
    for (int b = 0; b < WINDOW_BYTES; b++) stream_bytes.push_back(x[BYTE_W*b +: BYTE_W]);
    for (int i = emitted.size() - 1; i >= 0; i--) stream_bytes.push_back(emitted[i]);
  endfunction

  // Next four stream bytes from pos; pad past the end with noise.
  function automatic logic [WINDOW_W-1:0] window_at(input int pos);
    logic [WINDOW_W-1:0] w;
    w = $urandom;
    for (int b = 0; b < WINDOW_BYTES; b++)
      if (pos + b < stream_bytes.size()) w[BYTE_W*b +: BYTE_W] = stream_bytes[pos + b];
    return w;
  endfunction

  // Make sure the next decode reads only written table entries. With from_dist set,
  // also reload any entry that disagrees with the current stream's alphabet.
  function automatic void prepare_decode(input bit from_dist);
    bit [SCALE_BITS-1:0] slot;
    bit [7:0]            code;
    int                  di;
    in_item_t            it;
    if (!live[MODEL_PLAN]) return;
    slot = coder[MODEL_PLAN][SCALE_BITS-1:0];
    di   = dist_index(slot);
    if (!slot_set[MODEL_PLAN][slot] ||
        (from_dist && slot_tab[MODEL_PLAN][slot] != dist_code[di])) begin
      it = random_word(KIND_LOAD_SLOT);
      it.slot_index = SLOT_IDX_W'(slot);
      if (from_dist) it.symbol_code = dist_code[di];
      void'(plan_push(it));
    end
    code = slot_tab[MODEL_PLAN][slot];
    if (!sym_set[MODEL_PLAN][code] ||
        (from_dist && (freq_tab[MODEL_PLAN][code] != FREQ_W'(dist_freq[di]) ||
                       cum_tab[MODEL_PLAN][code] != CUM_W'(dist_cum[di])))) begin
      it = random_word(KIND_LOAD_SYM);
      it.symbol_code = code;
      if (from_dist) begin
        it.frequency = FREQ_W'(dist_freq[di]);
        it.cum_start = CUM_W'(dist_cum[di]);
      end
      void'(plan_push(it));
    end
  endfunction

  // Directed opening: range edges of start and finish, no-start decodes, the
  // renormalization limit, a zero-byte decode, table extremes and unused kinds.
  task automatic plan_directed();
    void'(plan_push(word_of(KIND_DECODE, '1, '1, '1, '1, '1)));
    void'(plan_push(word_of(KIND_FINISH, '0, '0, '0, '0, '0)));
    void'(plan_push(word_of(KIND_START, '1, '1, '1, '1, 32'h007F_FFFF)));
    void'(plan_push(word_of(KIND_START, '0, '0, '0, '0, 32'h8000_0000)));
    void'(plan_push(word_of(KIND_START, '0, '0, '0, '0, 32'hFFFF_FFFF)));
    void'(plan_push(word_of(KIND_DECODE, '0, '0, '0, '0, '0)));
    void'(plan_push(word_of(KIND_START, '0, '0, '0, '0, 32'h0080_0000)));
    void'(plan_push(word_of(KIND_FINISH, '1, '1, '1, '1, '1)));
    void'(plan_push(word_of(KIND_DECODE, '0, '0, '0, '0, '1)));
    // zero frequency drives the state to zero: three bytes, state stays below bound
    void'(plan_push(word_of(KIND_LOAD_SLOT, '0, '0, '1, '1, '1)));
    void'(plan_push(word_of(KIND_LOAD_SYM, '1, '0, '0, '0, '1)));
    void'(plan_push(word_of(KIND_START, '0, '0, '0, '0, 32'h0080_0000)));
    void'(plan_push(word_of(KIND_DECODE, '0, '0, '0, '0, '0)));
    void'(plan_push(word_of(KIND_FINISH, '0, '0, '0, '0, '0)));
    // full-scale frequency leaves the state alone: zero bytes used
    void'(plan_push(word_of(KIND_LOAD_SYM, '0, '0, FREQ_W'(SLOT_DEPTH), '0, '0)));
    void'(plan_push(word_of(KIND_START, '0, '0, '0, '0, 32'h0080_0000)));
    void'(plan_push(word_of(KIND_DECODE, '0, '0, '0, '0, '1)));
    void'(plan_push(word_of(KIND_FINISH, '0, '0, '0, '0, '0)));
    // top slot, top code, widest frequency and start, top state
    void'(plan_push(word_of(KIND_LOAD_SLOT, '1, '1, '0, '0, '0)));
    void'(plan_push(word_of(KIND_LOAD_SYM, '0, '1, '1, '1, '0)));
    void'(plan_push(word_of(KIND_START, '0, '0, '0, '0, 32'h7FFF_FFFF)));
    void'(plan_push(word_of(KIND_DECODE, '0, '0, '0, '0, '1)));
    void'(plan_push(word_of(KIND_FINISH, '0, '0, '0, '0, '0)));
    void'(plan_push(word_of(KIND_SPARE_FIRST, '1, '1, '1, '1, '1)));
    void'(plan_push(word_of(KIND_SPARE_LAST, '1, '1, '1, '1, '1)));
  endtask

  // One well-formed stream with random content; now and then truncate it, corrupt
  // its start word or drop its finish.
  task automatic plan_stream();
    int        msg_len;
    int        n_dec;
    int        pos;
    int        flip;
    in_item_t  it;
    out_item_t r;
    make_distribution();
    msg_len = $urandom_range(MAX_MSG_LEN, 1);
    encode_message(msg_len);
    n_dec = msg_len;
    if ($urandom_range(9, 0) == 0) n_dec = $urandom_range(msg_len - 1, 0);
    it = random_word(KIND_START);
    it.window = window_at(0);
    if ($urandom_range(19, 0) == 0) begin
      flip = $urandom_range(WINDOW_W - 1, 0);
      it.window[flip] = ~it.window[flip];
    end
    r = plan_push(it);
    pos = r.bytes_used;
    for (int i = 0; i < n_dec; i++) begin
      prepare_decode(1'b1);
      it = random_word(KIND_DECODE);
      it.window = window_at(pos);
      r = plan_push(it);
      pos += r.bytes_used;
    end
    if ($urandom_range(9, 0) != 0) void'(plan_push(random_word(KIND_FINISH)));
  endtask

  // Random words of every kind with random table contents.
  task automatic plan_noise(input int n);
    in_item_t it;
    repeat (n) begin
      case ($urandom_range(9, 0))
        0, 1: it = random_word(KIND_LOAD_SLOT);
        2, 3: it = random_word(KIND_LOAD_SYM);
        4, 5: begin
          it = random_word(KIND_START);
          case ($urandom_range(3, 0))
            0: it.window = $urandom_range(32'h7FFF_FFFF, 32'h0080_0000);
            1: it.window = $urandom_range(1, 0) ? 32'h007F_FFFF : 32'h0080_0000;
            2: it.window = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: ;
          endcase
        end
        6, 7: begin
          prepare_decode(1'b0);
          it = random_word(KIND_DECODE);
        end
        8: it = random_word(KIND_FINISH);
        default: it = random_word(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)));
      endcase
      void'(plan_push(it));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer the oldest queued word, with random idle bursts
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (send_gap == 0 && queued_words.size() >= QUIET_TAIL && $urandom_range(15, 0) == 0)
        send_gap = $urandom_range(12, 1);
      if (send_gap > 0) begin
        // hold push low for the rest of the burst
        push <= 1'b0;
        send_gap--;
      end else if (queued_words.size() != 0) begin
        push    <= 1'b1;
        in_item <= queued_words[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pop with random stall bursts and one long hold that backs the block up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (!hold_done && words_out >= HOLD_AT) begin
      // hold off long enough for full to rise while the sender keeps offering
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else begin
      if (recv_gap == 0 && queued_words.size() >= QUIET_TAIL && $urandom_range(15, 0) == 0)
        recv_gap = $urandom_range(12, 1);
      if (recv_gap > 0) begin
        pop <= 1'b0;
        recv_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on accept, compare on pop
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (rst_n) begin
      if (push && !full) begin
        predicted_words.push_back(rans_apply(MODEL_CHECK, in_item));
        void'(queued_words.pop_front());
      end
      if (pop && !empty) begin
        words_out++;
        if (predicted_words.size() == 0) begin
          $error("result word with nothing predicted: symbol %0d bytes %0d status %0d",
                 out_item.decoded_symbol, out_item.bytes_used, out_item.status);
          fail_count++;
        end else begin
          want = predicted_words.pop_front();
          if (out_item.decoded_symbol !== want.decoded_symbol) begin
            $error("decoded_symbol: expected %0d, got %0d",
                   want.decoded_symbol, out_item.decoded_symbol);
            fail_count++;
          end
          if (out_item.bytes_used !== want.bytes_used) begin
            $error("bytes_used: expected %0d, got %0d", want.bytes_used, out_item.bytes_used);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    in_item = '0;
    plan_directed();
    // mostly well-formed streams, the rest noise bursts
    while (queued_words.size() < ITEM_TARGET) begin
      if ($urandom_range(3, 0) != 0) plan_stream();
      else plan_noise($urandom_range(6, 1));
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // drain: every word sent and every result back, then catch stray results
    while (queued_words.size() != 0 || predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
design/rbd_pkg.sv
design/rbd_front.sv
design/rbd_back.sv
design/rans_byte_decoder_top.sv
bench/rans_byte_decoder_top_tb.sv
